@@ hw/rtl/sect_pkg.sv @@
// ----------------------------------------------------------------------------
// sect_pkg
// Shared direction type and codes for the swept edge collision test.
// ----------------------------------------------------------------------------
package sect_pkg;

  typedef enum logic [1:0] {
    DIR_POS_X = 2'd0,
    DIR_NEG_X = 2'd1,
    DIR_POS_Y = 2'd2,
    DIR_NEG_Y = 2'd3
  } dir_e;

endpackage

@@ hw/rtl/sect_div.sv @@
// ----------------------------------------------------------------------------
// sect_div
// Pipelined restoring divider, one quotient bit per stage, with stall.
// ----------------------------------------------------------------------------
module sect_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q [NW];
  logic [NW-1:0] n_q [NW];
  logic [DW:0]   r_q [NW];
  logic [DW-1:0] d_q [NW];
  logic [SW-1:0] s_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          vin;
    logic [NW-1:0] nin;
    logic [DW:0]   rin;
    logic [DW-1:0] din;
    logic [SW-1:0] sin;
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    logic          ge;
    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign nin = num_i;
      assign rin = '0;
      assign din = den_i;
      assign sin = side_i;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign nin = n_q[k-1];
      assign rin = r_q[k-1];
      assign din = d_q[k-1];
      assign sin = s_q[k-1];
    end
    assign sh = {rin, nin[NW-1]};
    assign df = sh - {2'b00, din};
    assign ge = !df[DW+1];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vin;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        r_q[k] <= ge ? df[DW:0] : sh[DW:0];
        n_q[k] <= {nin[NW-2:0], ge};
        d_q[k] <= din;
        s_q[k] <= sin;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = n_q[NW-1];
  assign side_o  = s_q[NW-1];

endmodule

@@ hw/rtl/swept_edge_collision_test.sv @@
// ----------------------------------------------------------------------------
// swept_edge_collision_test
// Swept test of two axis-aligned edges: hit flag, penetration, contact length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one edge pair per transaction;
//   the output channel (out_valid_o/out_ready_i) returns exactly one result
//   per pair, in order.
//   Throughput is one pair per cycle unless a stall on out_ready_i holds the
//   pipeline. The stages are a setup stage, a multiply stage, the
//   bit-per-stage divider computing the tangent shift (2*COORD_WIDTH
//   quotient stages) and the output register.
//   The pipeline advances as a whole when the output register is empty or
//   being taken; a stall on out_ready_i holds every stage, and in_ready_o
//   follows that advance.
//   Reset clears all valid bits; no pair is in flight after reset.
// ----------------------------------------------------------------------------
module swept_edge_collision_test #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] disp_x_i,
  input  logic signed [COORD_WIDTH-1:0] disp_y_i,
  input  logic signed [COORD_WIDTH-1:0] a_pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_pos_y_i,
  input  sect_pkg::dir_e                a_dir_i,
  input  logic        [COORD_WIDTH-2:0] a_length_i,
  input  logic signed [COORD_WIDTH-1:0] b_pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_pos_y_i,
  input  sect_pkg::dir_e                b_dir_i,
  input  logic        [COORD_WIDTH-2:0] b_length_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] pen_x_o,
  output logic signed [COORD_WIDTH-1:0] pen_y_o,
  output logic        [COORD_WIDTH-2:0] contact_len_o
);
  import sect_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int EW = CW + 2;
  localparam int NW = 2 * CW;
  // side: ok, xaxis, tie_rej, neg, pen(EW), at(EW), bt(EW), la, lb
  localparam int SW = 4 + 3 * EW + 2 * (CW - 1);
  localparam logic signed [EW-1:0] PEN_MAX = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [EW-1:0] PEN_MIN = {{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  logic signed [EW-1:0] a, b, d, at, bt, dt, df, pen, s_ba, s_d;
  logic xaxis, sneg, ok0;
  logic [CW-1:0] mag, num, den;

  always_comb begin
    xaxis = (a_dir_i == DIR_POS_X) || (a_dir_i == DIR_NEG_X);
    sneg  = (a_dir_i == DIR_NEG_X) || (a_dir_i == DIR_NEG_Y);
    a  = EW'(xaxis ? a_pos_x_i : a_pos_y_i);
    b  = EW'(xaxis ? b_pos_x_i : b_pos_y_i);
    d  = EW'(xaxis ? disp_x_i  : disp_y_i);
    at = EW'(xaxis ? a_pos_y_i : a_pos_x_i);
    bt = EW'(xaxis ? b_pos_y_i : b_pos_x_i);
    dt = EW'(xaxis ? disp_y_i  : disp_x_i);
    df  = b - a;
    pen = a - b + d;
    s_ba = sneg ? -df : df;
    s_d  = sneg ? -d : d;
    ok0 = (b_dir_i == dir_e'(a_dir_i ^ 2'd1)) && !s_ba[EW-1]
          && ((sneg ? -pen : pen) > 0);
    mag = dt[EW-1] ? CW'(-dt) : CW'(dt);
    num = CW'(s_ba);
    den = CW'(s_d);
  end

  // stage 1: operands; stage 2: product
  logic          v1_q, v2_q;
  logic [CW-1:0] mag_q, num_q, den_q, den2_q;
  logic [SW-1:0] sd1_q, sd2_q;
  logic [NW-1:0] prod_q;
  logic          tie_rej;
  assign tie_rej = (disp_x_i < disp_y_i)
                   == ((a_dir_i == DIR_NEG_X) || (a_dir_i == DIR_POS_Y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q  <= mag;
      num_q  <= num;
      den_q  <= ok0 ? den : {{(CW-1){1'b0}}, 1'b1};
      sd1_q  <= {ok0, xaxis, tie_rej, dt[EW-1], pen, at, bt, a_length_i, b_length_i};
      prod_q <= mag_q * num_q;
      den2_q <= den_q;
      sd2_q  <= sd1_q;
    end
  end

  logic          v3;
  logic [NW-1:0] q;
  logic [SW-1:0] sd3;

  sect_div #(.NW(NW), .DW(CW), .SW(SW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(v2_q),
    .num_i  (prod_q),
    .den_i  (den2_q),
    .side_i (sd2_q),
    .valid_o(v3),
    .quo_o  (q),
    .side_o (sd3)
  );

  logic                 ok3, xa3, tr3, ng3;
  logic signed [EW-1:0] pen3, at3, bt3;
  logic [CW-2:0]        la3, lb3;
  logic signed [EW+1:0] la3x, lb3x;
  logic signed [EW+1:0] off, ca2, cb2, hi, lo, surf;
  logic signed [EW-1:0] p;
  logic                 hit;
  logic [CW-2:0]        clen;

  always_comb begin
    {ok3, xa3, tr3, ng3, pen3, at3, bt3, la3, lb3} = sd3;
    la3x = $signed((EW+2)'(la3));
    lb3x = $signed((EW+2)'(lb3));
    off = ng3 ? -(EW+2)'(q[CW:0]) : (EW+2)'(q[CW:0]);
    ca2 = ((EW+2)'(at3) + off) <<< 1;
    cb2 = (EW+2)'(bt3) <<< 1;
    hi = (ca2 + la3x < cb2 + lb3x) ? ca2 + la3x : cb2 + lb3x;
    lo = (ca2 - la3x > cb2 - lb3x) ? ca2 - la3x : cb2 - lb3x;
    surf = hi - lo;
    hit = ok3 && !surf[EW+1] && !((surf == 0) && tr3);
    if (pen3 > PEN_MAX) begin
      p = PEN_MAX;
    end else if (pen3 < PEN_MIN) begin
      p = PEN_MIN;
    end else begin
      p = pen3;
    end
    clen = (surf[EW+1:CW] != 0) ? {(CW-1){1'b1}} : surf[CW-1:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_o         <= hit;
      pen_x_o       <= (hit && xa3) ? p[CW-1:0] : '0;
      pen_y_o       <= (hit && !xa3) ? p[CW-1:0] : '0;
      contact_len_o <= hit ? clen : '0;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o)
      && $stable(pen_x_o) && $stable(pen_y_o) && $stable(contact_len_o))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow pipeline advance");
  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> pen_x_o == 0 && pen_y_o == 0 && contact_len_o == 0)
    else $error("miss with nonzero payload");
  a_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pen_x_o == 0 || pen_y_o == 0)
    else $error("penetration on both axes");

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the swept edge collision test against typed results and its own
// predictor: a table of directed edge pairs, then random pairs that are mostly
// built to collide, with idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sect_pkg::*;

  localparam int  CW        = 32;
  localparam int  LATENCY   = 2 * CW + 3;
  localparam int  N_RANDOM  = 830;
  localparam int  CYCLE_CAP = 400000;
  localparam logic signed [CW-1:0] LEN_MAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] CMAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] CMIN = 32'sh80000000;
  localparam logic signed [CW-1:0] ONE  = 32'sh00010000;

  typedef struct packed {
    logic signed [CW-1:0] dx, dy, ax, ay;
    dir_e                 ad;
    logic        [CW-2:0] la;
    logic signed [CW-1:0] bx, by;
    dir_e                 bd;
    logic        [CW-2:0] lb;
  } pair_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] pen_x, pen_y;
    logic        [CW-2:0] clen;
  } contact_t;

  typedef struct packed {
    pair_t    pair;
    logic     typed;
    contact_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  pair_t drv = '0;
  logic in_ready, out_valid, hit;
  logic signed [CW-1:0] pen_x, pen_y;
  logic [CW-2:0] clen;

  contact_t pending_contacts[$];
  row_t     rows[$];
  int       errors = 0;
  int       cycles = 0;
  int       tx_idle = 0;
  int       rx_idle = 0;

  always #1 clk_i = ~clk_i;

  swept_edge_collision_test i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .disp_x_i(drv.dx), .disp_y_i(drv.dy),
    .a_pos_x_i(drv.ax), .a_pos_y_i(drv.ay), .a_dir_i(drv.ad), .a_length_i(drv.la),
    .b_pos_x_i(drv.bx), .b_pos_y_i(drv.by), .b_dir_i(drv.bd), .b_length_i(drv.lb),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .hit_o(hit), .pen_x_o(pen_x), .pen_y_o(pen_y), .contact_len_o(clen)
  );

  function automatic contact_t predict_contact(pair_t p);
    contact_t r;
    logic xaxis;
    longint s, a, b, d, at, bt, dt, pen, off, ca2, cb2, up, lo, surf2, clen_l;
    longint la_l, lb_l;
    longint unsigned num, den, mag, q;
    r = '0;
    if (p.bd != dir_e'(p.ad ^ 2'b01)) return r;
    xaxis = (p.ad == DIR_POS_X) || (p.ad == DIR_NEG_X);
    s  = (p.ad == DIR_NEG_X || p.ad == DIR_NEG_Y) ? -1 : 1;
    a  = xaxis ? longint'(p.ax) : longint'(p.ay);
    b  = xaxis ? longint'(p.bx) : longint'(p.by);
    d  = xaxis ? longint'(p.dx) : longint'(p.dy);
    at = xaxis ? longint'(p.ay) : longint'(p.ax);
    bt = xaxis ? longint'(p.by) : longint'(p.bx);
    dt = xaxis ? longint'(p.dy) : longint'(p.dx);
    la_l = longint'(p.la);
    lb_l = longint'(p.lb);
    if (s * (a - b) > 0) return r;
    pen = a - b + d;
    if (s * pen <= 0) return r;
    num = s * (b - a);
    den = s * d;
    mag = dt < 0 ? -dt : dt;
    q   = (mag * num) / den;
    off = dt < 0 ? -longint'(q) : longint'(q);
    ca2 = 2 * (at + off);
    cb2 = 2 * bt;
    up  = (ca2 + la_l < cb2 + lb_l) ? ca2 + la_l : cb2 + lb_l;
    lo  = (ca2 - la_l > cb2 - lb_l) ? ca2 - la_l : cb2 - lb_l;
    surf2 = up - lo;
    if (surf2 < 0) return r;
    if (surf2 == 0 &&
        ((p.dx < p.dy) == (p.ad == DIR_NEG_X || p.ad == DIR_POS_Y))) return r;
    if (pen > longint'(CMAX)) pen = CMAX;
    if (pen < longint'(CMIN)) pen = CMIN;
    clen_l = surf2 / 2;
    if (clen_l > longint'(CMAX)) clen_l = CMAX;
    r.hit = 1'b1;
    if (xaxis) r.pen_x = pen[CW-1:0];
    else       r.pen_y = pen[CW-1:0];
    r.clen = clen_l[CW-2:0];
    return r;
  endfunction

  function automatic pair_t mk(logic signed [CW-1:0] dx, dy, ax, ay, dir_e ad,
                               logic signed [CW-1:0] la, bx, by,
                               dir_e bd, logic signed [CW-1:0] lb);
    return '{dx, dy, ax, ay, ad, la[CW-2:0], bx, by, bd, lb[CW-2:0]};
  endfunction

  function automatic logic signed [CW-1:0] rnd_span(int unsigned span);
    return $signed($urandom_range(0, 2 * span)) - $signed(span);
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    logic xaxis;
    logic signed [CW-1:0] s, gap, a, b, d, at, bt, dt;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, 2'($urandom)};
      if ($urandom_range(0, 1)) p.bd = dir_e'(p.ad ^ 2'b01);
      return p;
    end
    p.ad  = dir_e'($urandom_range(0, 3));
    p.bd  = (kind < 27) ? dir_e'($urandom_range(0, 3)) : dir_e'(p.ad ^ 2'b01);
    xaxis = (p.ad == DIR_POS_X) || (p.ad == DIR_NEG_X);
    s     = (p.ad == DIR_NEG_X || p.ad == DIR_NEG_Y) ? -1 : 1;
    b     = rnd_span(1 << 24);
    gap   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 1 << 18);
    a     = b - s * gap;
    case ($urandom_range(0, 9))
      0:       d = s * gap;
      1:       d = -s * $urandom_range(0, 1 << 18);
      default: d = s * (gap + $urandom_range(1, 1 << 19));
    endcase
    p.la = (CW-1)'(($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 1 << 20));
    p.lb = (CW-1)'(($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 1 << 20));
    bt = rnd_span(1 << 24);
    if (kind < 40) begin
      dt   = 0;
      p.la = {p.la[CW-2:1], 1'b0};
      p.lb = {p.lb[CW-2:1], 1'b0};
      at   = bt + s * $signed({1'b0, p.la} + {1'b0, p.lb}) / 2;
      if ($urandom_range(0, 1)) at = bt - ($signed({1'b0, p.la}) + $signed({1'b0, p.lb})) / 2;
    end else begin
      dt = rnd_span(1 << 20);
      at = bt + rnd_span(1 << 20);
    end
    if (xaxis) begin
      p.ax = a; p.bx = b; p.dx = d; p.ay = at; p.by = bt; p.dy = dt;
    end else begin
      p.ay = a; p.by = b; p.dy = d; p.ax = at; p.bx = bt; p.dx = dt;
    end
    if (kind < 40 && $urandom_range(0, 1)) begin
      if (xaxis) begin
        p.ax = p.bx;
        p.dy = p.dx + s;
      end else begin
        p.ay = p.by;
        p.dx = p.dy + s;
      end
    end
    return p;
  endfunction

  task automatic send_pair(pair_t p, logic typed, contact_t res);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    drv      <= p;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    pending_contacts.push_back(typed ? res : predict_contact(p));
    @(negedge clk_i);
  endtask

  function automatic void check_field(string name, longint expv, longint gotv);
    if (expv != gotv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, gotv);
      errors++;
    end
  endfunction

  always @(negedge clk_i) out_ready <= ($urandom_range(0, 99) >= rx_idle);

  always @(posedge clk_i) begin
    contact_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_contacts.size() == 0) begin
        $display("%0t: unexpected transaction, actual hit %0b", $time, hit);
        errors++;
      end else begin
        e = pending_contacts.pop_front();
        check_field("hit", e.hit, hit);
        check_field("pen_x", e.pen_x, pen_x);
        check_field("pen_y", e.pen_y, pen_y);
        check_field("contact_len", e.clen, clen);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // no hit: normals not opposite, far side, zero depth; then plain hits
    rows.push_back('{mk(ONE, 0, 0, 0, DIR_POS_X, ONE, ONE, 0, DIR_POS_X, ONE), 1'b1, '0});
    rows.push_back('{mk(ONE, 0, 2 * ONE, 0, DIR_POS_X, ONE, ONE, 0, DIR_NEG_X, ONE),
                     1'b1, '0});
    rows.push_back('{mk(ONE, 0, 0, 0, DIR_POS_X, ONE, ONE, 0, DIR_NEG_X, ONE), 1'b1, '0});
    rows.push_back('{mk(2 * ONE, 0, 0, 0, DIR_POS_X, 2 * ONE, ONE, 0, DIR_NEG_X, 2 * ONE),
                     1'b1, '{1'b1, ONE, 32'sd0, 31'h20000}});
    rows.push_back('{mk(0, -2 * ONE, 0, 0, DIR_NEG_Y, ONE, 0, -ONE, DIR_POS_Y, ONE), 1'b0, '0});
    rows.push_back('{mk(0, 2 * ONE, 0, 0, DIR_POS_Y, ONE, 0, ONE, DIR_NEG_Y, ONE), 1'b0, '0});
    rows.push_back('{mk(-2 * ONE, ONE, 0, 0, DIR_NEG_X, ONE, -ONE, 0, DIR_POS_X, ONE),
                     1'b0, '0});
    // touching ends, both tie outcomes
    rows.push_back('{mk(2 * ONE, 0, 0, 0, DIR_POS_X, 2 * ONE, ONE, 2 * ONE, DIR_NEG_X,
                        2 * ONE), 1'b0, '0});
    rows.push_back('{mk(2 * ONE, 3 * ONE, 0, 0, DIR_POS_X, 2 * ONE, ONE, 2 * ONE, DIR_NEG_X,
                        2 * ONE), 1'b0, '0});
    rows.push_back('{mk(0, 2 * ONE, 0, 0, DIR_POS_Y, 2 * ONE, 2 * ONE, ONE, DIR_NEG_Y,
                        2 * ONE), 1'b0, '0});
    rows.push_back('{mk(ONE, 2 * ONE, 0, 0, DIR_POS_Y, 2 * ONE, 2 * ONE, ONE, DIR_NEG_Y,
                        2 * ONE), 1'b0, '0});
    // separated along the tangent
    rows.push_back('{mk(2 * ONE, 0, 0, 0, DIR_POS_X, ONE, ONE, 9 * ONE, DIR_NEG_X, ONE),
                     1'b0, '0});
    // extremes
    rows.push_back('{mk(CMAX, CMAX, CMIN, 0, DIR_POS_X, LEN_MAX, CMAX, 0, DIR_NEG_X, LEN_MAX),
                     1'b0, '0});
    rows.push_back('{mk(CMIN, CMIN, CMAX, CMAX, DIR_NEG_X, LEN_MAX, CMIN, CMIN, DIR_POS_X,
                        LEN_MAX), 1'b0, '0});
    rows.push_back('{mk(CMIN, CMIN, 0, 0, DIR_NEG_Y, LEN_MAX, 0, 0, DIR_POS_Y, LEN_MAX),
                     1'b0, '0});
    rows.push_back('{mk(CMAX, CMIN, CMIN, CMIN, DIR_POS_Y, 0, CMAX, CMAX, DIR_NEG_Y, 0),
                     1'b0, '0});
    rows.push_back('{mk(-1, -1, -1, -1, DIR_NEG_Y, LEN_MAX, -1, -1, DIR_NEG_Y, LEN_MAX),
                     1'b1, '0});
    rows.push_back('{mk(CMAX, -1, 0, CMIN, DIR_POS_X, 1, 1, CMAX, DIR_NEG_X, 1), 1'b0, '0});

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    tx_idle = 36; rx_idle = 86;
    foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].res);
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 36 : (ph == 1) ? 86 : 0;
      rx_idle = (ph == 0) ? 86 : (ph == 1) ? 36 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        if (ph == 1 && i == 100) begin
          in_valid <= 1'b0;
          while (pending_contacts.size() != 0) @(negedge clk_i);
        end
        send_pair(random_pair(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_contacts.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/sect_pkg.sv
hw/rtl/sect_div.sv
hw/rtl/swept_edge_collision_test.sv
verif/tb.sv
